### design/msr_pkg.sv
// ----------------------------------------------------------------------------
// msr_pkg: shared types for the multi-stack set unit
// Item and result structs, status codes, opcodes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package msr_pkg;

  // Opcodes
  localparam logic OP_PUSH   = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_DONE    = 3'd0,
    STAT_FULL    = 3'd1,
    STAT_DUP     = 3'd2,
    STAT_EMPTY   = 3'd3,
    STAT_MISSING = 3'd4
  } msr_status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT
  } msr_state_t;

  // Input item
  typedef struct packed {
    logic        opcode;
    logic [2:0]  stack_sel;
    logic [15:0] segment;
  } msr_in_t;

  // Result item
  typedef struct packed {
    logic [2:0] status;
    logic       found;
  } msr_out_t;

  // Result handed from the sequencer to the output register
  typedef struct packed {
    logic     vld;
    msr_out_t item;
  } msr_rsp_t;

endpackage

`default_nettype wire

### design/msr_ram.sv
// ----------------------------------------------------------------------------
// msr_ram: entry storage
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module msr_ram #(
  parameter int Words = 128,
  parameter int AddrW = 7
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [15:0]      wdata,
  input  wire logic             re,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [15:0]      rdata
);

  logic [15:0] mem [Words];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/msr_seq.sv
// ----------------------------------------------------------------------------
// msr_seq: operation sequencer
// Holds the fill counts, walks one stack through the RAM one entry per
// cycle with a single compare unit, and compacts the stack on a remove.
// ----------------------------------------------------------------------------
`default_nettype none

module msr_seq #(
  parameter int NUM_STACKS  = 8,
  parameter int STACK_DEPTH = 16,
  parameter int AddrW       = 7
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire msr_pkg::msr_in_t  in_item,
  output logic                   ram_we,
  output logic      [AddrW-1:0]  ram_waddr,
  output logic      [15:0]       ram_wdata,
  output logic                   ram_re,
  output logic      [AddrW-1:0]  ram_raddr,
  input  wire logic [15:0]       ram_rdata,
  output msr_pkg::msr_rsp_t      rsp
);

  import msr_pkg::*;

  localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] OneC   = CW'(1);

  msr_state_t          state_r, state_nxt;
  logic                op_r, op_nxt;
  logic [SW-1:0]       stk_r, stk_nxt;
  logic [15:0]         seg_r, seg_nxt;
  logic [AddrW-1:0]    base_r, base_nxt;
  logic [CW-1:0]       n_r, n_nxt;
  logic [CW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [CW-1:0]       cmp_ptr_r, cmp_ptr_nxt;
  logic [CW-1:0]       fill_r [NUM_STACKS];

  // fill count update
  logic                fill_we;
  logic [SW-1:0]       fill_idx;
  logic [CW-1:0]       fill_val;

  // decode of the incoming item
  logic [SW-1:0]       in_stk;
  logic                in_sel_ok;
  logic [CW-1:0]       in_n;
  logic [AddrW-1:0]    in_base;
  logic [CW-1:0]       n_last;
  logic                hit;

  assign in_stk    = SW'(in_item.stack_sel);
  assign in_sel_ok = (32'(in_item.stack_sel) < NUM_STACKS);
  assign in_n      = in_sel_ok ? fill_r[in_stk] : '0;
  assign in_base   = AddrW'(32'(in_stk) * STACK_DEPTH);
  assign n_last    = n_r - OneC;
  assign hit       = (ram_rdata == seg_r);

  // state and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    stk_r     <= stk_nxt;
    seg_r     <= seg_nxt;
    base_r    <= base_nxt;
    n_r       <= n_nxt;
    rd_ptr_r  <= rd_ptr_nxt;
    cmp_ptr_r <= cmp_ptr_nxt;
  end

  // fill counts, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        fill_r[i] <= '0;
      end
    end else if (fill_we) begin
      fill_r[fill_idx] <= fill_val;
    end
  end

  // next state and outputs
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    stk_nxt     = stk_r;
    seg_nxt     = seg_r;
    base_nxt    = base_r;
    n_nxt       = n_r;
    rd_ptr_nxt  = rd_ptr_r;
    cmp_vld_nxt = 1'b0;
    cmp_ptr_nxt = rd_ptr_r;
    busy        = (state_r != S_IDLE);
    ram_we      = 1'b0;
    ram_waddr   = base_r + AddrW'(n_r);
    ram_wdata   = seg_r;
    ram_re      = 1'b0;
    ram_raddr   = base_r + AddrW'(rd_ptr_r);
    fill_we     = 1'b0;
    fill_idx    = stk_r;
    fill_val    = n_r;
    rsp         = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt     = in_item.opcode;
          stk_nxt    = in_stk;
          seg_nxt    = in_item.segment;
          base_nxt   = in_base;
          n_nxt      = in_n;
          rd_ptr_nxt = '0;
          if (!in_sel_ok) begin
            // nonexistent stack: ignored
            rsp.vld         = 1'b1;
            rsp.item.status = (in_item.opcode == OP_REMOVE) ? STAT_EMPTY : STAT_FULL;
          end else if (in_item.opcode == OP_PUSH && in_n == DepthC) begin
            rsp.vld         = 1'b1;
            rsp.item.status = STAT_FULL;
          end else if (in_item.opcode == OP_REMOVE && in_n == '0) begin
            rsp.vld         = 1'b1;
            rsp.item.status = STAT_EMPTY;
          end else if (in_item.opcode == OP_PUSH && in_n == '0) begin
            // empty stack: nothing to search
            ram_we          = 1'b1;
            ram_waddr       = in_base;
            ram_wdata       = in_item.segment;
            fill_we         = 1'b1;
            fill_idx        = in_stk;
            fill_val        = OneC;
            rsp.vld         = 1'b1;
            rsp.item.status = STAT_DONE;
          end else begin
            state_nxt = S_SEARCH;
          end
        end
      end

      S_SEARCH: begin
        // issue the next read
        if (rd_ptr_r < n_r) begin
          ram_re      = 1'b1;
          rd_ptr_nxt  = rd_ptr_r + OneC;
          cmp_vld_nxt = 1'b1;
        end
        // compare the entry read last cycle
        if (cmp_vld_r) begin
          if (hit) begin
            if (op_r == OP_PUSH) begin
              rsp.vld         = 1'b1;
              rsp.item.status = STAT_DUP;
              state_nxt       = S_IDLE;
            end else begin
              fill_we  = 1'b1;
              fill_val = n_last;
              if (cmp_ptr_r == n_last) begin
                // top entry: no compaction
                rsp.vld         = 1'b1;
                rsp.item.status = STAT_DONE;
                rsp.item.found  = 1'b1;
                state_nxt       = S_IDLE;
              end else begin
                ram_re      = 1'b0;
                rd_ptr_nxt  = cmp_ptr_r + OneC;
                cmp_vld_nxt = 1'b0;
                state_nxt   = S_SHIFT;
              end
            end
          end else if (cmp_ptr_r == n_last) begin
            // searched the whole stack without a match
            rsp.vld   = 1'b1;
            state_nxt = S_IDLE;
            if (op_r == OP_PUSH) begin
              ram_we          = 1'b1;
              fill_we         = 1'b1;
              fill_val        = n_r + OneC;
              rsp.item.status = STAT_DONE;
            end else begin
              rsp.item.status = STAT_MISSING;
            end
          end
        end
      end

      S_SHIFT: begin
        // read entry i+1, write it to i on the next cycle
        if (rd_ptr_r < n_r) begin
          ram_re      = 1'b1;
          rd_ptr_nxt  = rd_ptr_r + OneC;
          cmp_vld_nxt = 1'b1;
        end
        if (cmp_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = base_r + AddrW'(cmp_ptr_r - OneC);
          ram_wdata = ram_rdata;
          if (cmp_ptr_r == n_last) begin
            rsp.vld         = 1'b1;
            rsp.item.status = STAT_DONE;
            rsp.item.found  = 1'b1;
            state_nxt       = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/multi_stack_set_with_remove_unit.sv
// The result strobes in the cycle after the accepting edge for a full, empty or
// unknown stack and for a push onto an empty stack; otherwise it strobes after the
// search has compared its n entries, and after the shift pass when a remove compacts.
// The next command is taken at the edge that ends the strobe; while a search or shift
// runs, busy holds off new commands; one entry per cycle through one read port.
// Synchronous active-low reset clears all fill counts at once; the receiver cannot stall.
// ----------------------------------------------------------------------------
// multi_stack_set_with_remove_unit: bank of bounded stacks with search
// Push with capacity and duplicate check, remove with in-order compaction.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_stack_set_with_remove_unit #(
  parameter int NUM_STACKS  = 8,
  parameter int STACK_DEPTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire msr_pkg::msr_in_t in_item,
  output logic                  out_valid,
  output msr_pkg::msr_out_t     out_item
);

  import msr_pkg::*;

  localparam int Words = NUM_STACKS * STACK_DEPTH;
  localparam int AddrW = $clog2(Words);

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [15:0]      ram_wdata;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [15:0]      ram_rdata;
  msr_rsp_t         rsp;

  logic             out_valid_r;
  msr_out_t         out_item_r;

  msr_seq #(
    .NUM_STACKS  (NUM_STACKS),
    .STACK_DEPTH (STACK_DEPTH),
    .AddrW       (AddrW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .rsp       (rsp)
  );

  msr_ram #(
    .Words (Words),
    .AddrW (AddrW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result register: one-cycle strobe per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= rsp.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.vld) begin
      out_item_r <= rsp.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire
